@@ design/afl_pkg.sv @@
package afl_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = 32 + IDX_W;
   localparam int STEP_W = $clog2(SUM_W + 1);

   localparam logic [1:0] KIND_PUSH  = 2'd0;
   localparam logic [1:0] KIND_POP   = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;
   localparam logic [1:0] KIND_QUERY = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]          kind;
      logic signed [31:0]  sample;
      logic signed [15:0]  filter_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0]  head_value;
      logic [CNT_W-1:0]    fill_level;
      logic                is_empty;
      logic signed [31:0]  mean_value;
      logic signed [15:0]  last_kept;
      logic [1:0]          status;
   } rsp_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

@@ design/afl_cell.sv @@
module afl_cell (
   input  logic                 clock,
   input  afl_pkg::cell_ctl_type ctl,
   input  logic [31:0]          sample_in,
   input  logic [31:0]          neighbour_in,
   output logic [31:0]          value_out
);
   import afl_pkg::*;

   logic [31:0] value_ff;
   logic [31:0] value_in;

   always_comb begin
      value_in = value_ff;
      priority if (ctl.shift) begin
         value_in = neighbour_in;
      end else if (ctl.load) begin
         value_in = sample_in;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;

endmodule

@@ design/afl_divider.sv @@
module afl_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [afl_pkg::SUM_W-1:0]  dividend,
   input  logic [afl_pkg::CNT_W-1:0]  divisor,
   output logic [afl_pkg::SUM_W-1:0]  quotient,
   output logic                       done
);
   import afl_pkg::*;

   logic                busy_ff, busy_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [SUM_W-1:0]    quo_ff, quo_in;
   logic [CNT_W:0]      trial;
   logic [CNT_W:0]      diff;

   always_comb begin
      trial = {rem_ff, quo_ff[SUM_W-1]};
      diff = trial - {1'b0, divisor};
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(SUM_W);
         rem_in = '0;
         quo_in = dividend;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = diff[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done = !busy_ff;

endmodule

@@ design/averaging_fifo_with_filtered_last.sv @@
// One word is accepted at a time; a new word is taken only once the result of the last
// one has been issued, which waits for the bit-serial divider that forms the mean
// (one quotient bit per cycle over the 36-bit running sum) and for a free result slot.
// The ring of sample cells rotates once through all entries meanwhile.
// Synchronous active-high reset empties the queue; sample cells are not cleared.
module averaging_fifo_with_filtered_last (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  afl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output afl_pkg::rsp_type rsp_data
);
   import afl_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic                state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]    pos_ff, pos_in;
   logic [1:0]          kind_ff, kind_in;
   logic [1:0]          status_ff, status_in;
   logic signed [15:0]  filter_ff, filter_in;
   logic signed [15:0]  last_ff, last_in;
   logic [31:0]         head_ff, head_in;
   logic                popped_ff, popped_in;
   logic                neg_ff, neg_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   cell_ctl_type        ctl [DEPTH];
   logic [31:0]         cell_value [DEPTH];
   logic                shift_all;
   logic                push_en;
   logic                accept;
   logic                finish;
   logic                div_start;
   logic                div_done;
   logic [SUM_W-1:0]    div_dividend;
   logic [SUM_W-1:0]    quotient;
   logic [SUM_W-1:0]    mean_full;
   logic [31:0]         head_cell;
   logic [15:0]         head_int;
   logic signed [SUM_W-1:0] sample_ext;
   logic signed [SUM_W-1:0] head_ext;

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         always_comb begin
            ctl[gi].shift = shift_all;
            ctl[gi].load = push_en && (count_ff == CNT_W'(gi));
         end
         afl_cell u_cell (
            .clock        (clock),
            .ctl          (ctl[gi]),
            .sample_in    (req_data.sample),
            .neighbour_in (cell_value[(gi + 1) % DEPTH]),
            .value_out    (cell_value[gi])
         );
      end
   endgenerate

   afl_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (count_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign head_cell = cell_value[0];
   assign sample_ext = {{IDX_W{req_data.sample[31]}}, req_data.sample};
   assign head_ext = {{IDX_W{head_cell[31]}}, head_cell};
   assign head_int = head_cell[31:16] + {15'd0, head_cell[31] & (|head_cell[15:0])};
   assign div_start = (state_ff == ST_SCAN) && (pos_ff == '0);
   assign div_dividend = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign mean_full = neg_ff ? SUM_W'(-quotient) : quotient;
   assign finish = (state_ff == ST_SCAN) && (pos_ff == CNT_W'(DEPTH)) && div_done
                   && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      sum_in = sum_ff;
      pos_in = pos_ff;
      kind_in = kind_ff;
      status_in = status_ff;
      filter_in = filter_ff;
      last_in = last_ff;
      head_in = head_ff;
      popped_in = popped_ff;
      neg_in = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      shift_all = 1'b0;
      push_en = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
               pos_in = '0;
               kind_in = req_data.kind;
               filter_in = req_data.filter_value;
               last_in = req_data.filter_value;
               status_in = STATUS_OK;
               head_in = '0;
               popped_in = 1'b0;
               unique case (req_data.kind)
                  KIND_PUSH: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        status_in = STATUS_FULL;
                     end else begin
                        push_en = 1'b1;
                        count_in = count_ff + 1'b1;
                        sum_in = sum_ff + sample_ext;
                     end
                  end
                  KIND_POP: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        shift_all = 1'b1;
                        count_in = count_ff - 1'b1;
                        sum_in = sum_ff - head_ext;
                        head_in = head_cell;
                        popped_in = 1'b1;
                     end
                  end
                  KIND_CLEAR: begin
                     count_in = '0;
                     sum_in = '0;
                  end
                  KIND_QUERY: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (pos_ff == '0) begin
               neg_in = sum_ff[SUM_W-1];
               if (!popped_ff && count_ff != '0) begin
                  head_in = head_cell;
               end
            end
            if (pos_ff < CNT_W'(DEPTH)) begin
               shift_all = 1'b1;
               pos_in = pos_ff + 1'b1;
               if (pos_ff < count_ff && head_cell != {filter_ff, 16'd0}) begin
                  last_in = head_int;
               end
            end
            if (finish) begin
               state_in = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in.head_value = head_ff;
               rsp_data_in.fill_level = count_ff;
               rsp_data_in.is_empty = (count_ff == '0);
               rsp_data_in.mean_value = (count_ff == '0) ? 32'sd0 : mean_full[31:0];
               rsp_data_in.last_kept = last_ff;
               rsp_data_in.status = status_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         sum_ff <= '0;
         pos_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sum_ff <= sum_in;
         pos_ff <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in;
      status_ff <= status_in;
      filter_ff <= filter_in;
      last_ff <= last_in;
      head_ff <= head_in;
      popped_ff <= popped_in;
      neg_ff <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill level exceeds depth");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.kind == KIND_CLEAR |=> count_ff == '0)
      else $error("clear did not empty the queue");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      finish && status_ff == STATUS_FULL |-> kind_ff == KIND_PUSH && count_ff == CNT_W'(DEPTH))
      else $error("full status without a full queue");

   a_finish_after_ring: assert property (@(posedge clock) disable iff (reset)
      finish |-> pos_ff == CNT_W'(DEPTH) && div_done)
      else $error("result issued before the ring rotation or divide completed");

   a_empty_zero_sum: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE && count_ff == '0 |-> sum_ff == '0)
      else $error("empty queue holds a non-zero sum");

endmodule

@@ verif/tb_averaging_fifo_with_filtered_last.sv @@
module tb_averaging_fifo_with_filtered_last;
   import afl_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type word_q[$];
   rsp_type outcome_q[$];
   rsp_type want;

   logic signed [31:0] model_store [DEPTH];
   int                 model_rd = 0;
   int                 model_wr = 0;
   int                 model_cnt = 0;
   longint             model_sum = 0;

   int fail_count = 0;
   bit random_started = 1'b0;
   int gap_left = 0;
   bit tx_bursty = 1'b1;
   int stall_left = 0;
   int hold_left = 0;
   int rx_count = 0;
   bit hold_done = 1'b0;
   bit rx_bursty = 1'b1;

   averaging_fifo_with_filtered_last u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic rsp_type fifo_outcome(req_type w);
      rsp_type     r;
      longint      filt;
      longint      head;
      longint      mean;
      longint      last;
      longint      v;
      logic [1:0]  st;
      bit          popped;
      int          idx;
      filt = longint'(w.filter_value);
      head = 0;
      mean = 0;
      last = filt;
      st = STATUS_OK;
      popped = 1'b0;
      case (w.kind)
         KIND_PUSH: begin
            if (model_cnt >= DEPTH) begin
               st = STATUS_FULL;
            end else begin
               model_store[model_wr] = w.sample;
               model_wr = (model_wr + 1) % DEPTH;
               model_cnt++;
               model_sum += longint'(w.sample);
            end
         end
         KIND_POP: begin
            if (model_cnt == 0) begin
               st = STATUS_EMPTY;
            end else begin
               head = longint'(model_store[model_rd]);
               model_rd = (model_rd + 1) % DEPTH;
               model_cnt--;
               model_sum -= head;
               popped = 1'b1;
            end
         end
         KIND_CLEAR: begin
            model_rd = 0;
            model_wr = 0;
            model_cnt = 0;
            model_sum = 0;
         end
         default: begin
            if (model_cnt == 0) st = STATUS_EMPTY;
         end
      endcase
      if (!popped && model_cnt != 0) head = longint'(model_store[model_rd]);
      if (model_cnt != 0) mean = model_sum / longint'(model_cnt);
      idx = model_rd;
      for (int i = 0; i < model_cnt; i++) begin
         v = longint'(model_store[idx]);
         if (v != filt * 65536) last = v / 65536;
         idx = (idx + 1) % DEPTH;
      end
      r.head_value = head[31:0];
      r.fill_level = CNT_W'(model_cnt);
      r.is_empty = (model_cnt == 0);
      r.mean_value = mean[31:0];
      r.last_kept = last[15:0];
      r.status = st;
      return r;
   endfunction

   task automatic report_field(string nm, logic [31:0] exp_val, logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, nm, exp_val, act_val);
         fail_count++;
      end
   endtask

   task automatic queue_word(logic [1:0] k, logic signed [31:0] s, logic signed [15:0] f);
      req_type w;
      w.kind = k;
      w.sample = s;
      w.filter_value = f;
      word_q.push_back(w);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (word_q.size() != 0 || req_valid || outcome_q.size() != 0);
   endtask

   // Driver: a word is offered whenever the slot is free and no gap is pending.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_valid && req_ready) outcome_q.push_back(fifo_outcome(req_data));
         if ($urandom_range(0, 63) == 0) tx_bursty <= !tx_bursty;
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (word_q.size() != 0) begin
               req_data <= word_q.pop_front();
               req_valid <= 1'b1;
               if (tx_bursty && !(random_started && word_q.size() < 150)
                   && $urandom_range(0, 2) == 0) begin
                  gap_left <= $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: short random stalls, and one long hold-off that backs the block up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) rx_count <= rx_count + 1;
         if ($urandom_range(0, 99) == 0) rx_bursty <= !rx_bursty;
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (rx_count == 300 && !hold_done) begin
            hold_left <= 300;
            hold_done <= 1'b1;
            rsp_ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
         end else if (rx_bursty && !(random_started && word_q.size() < 150)
                      && $urandom_range(0, 15) == 0) begin
            stall_left <= $urandom_range(0, 7);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Monitor: every result word is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (outcome_q.size() == 0) begin
            $display("%0t: result with none expected, expected nothing, actual %p",
                     $time, rsp_data);
            fail_count++;
         end else begin
            want = outcome_q.pop_front();
            report_field("head_value", want.head_value, rsp_data.head_value);
            report_field("fill_level", want.fill_level, rsp_data.fill_level);
            report_field("is_empty", want.is_empty, rsp_data.is_empty);
            report_field("mean_value", want.mean_value, rsp_data.mean_value);
            report_field("last_kept", want.last_kept, rsp_data.last_kept);
            report_field("status", want.status, rsp_data.status);
         end
      end
   end

   initial begin
      logic [1:0]         kind;
      logic signed [31:0] smp;
      logic signed [15:0] filt;
      int                 push_bias;
      int                 roll;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      queue_word(KIND_QUERY, 32'sh0, 16'sh8000);
      queue_word(KIND_POP, 32'sh0, 16'sh7FFF);
      queue_word(KIND_PUSH, 32'sh7FFF_FFFF, 16'sh0);
      queue_word(KIND_PUSH, 32'sh8000_0000, 16'sh7FFF);
      queue_word(KIND_PUSH, 32'sh0, 16'sh0);
      queue_word(KIND_PUSH, 32'shFFFF_FFFF, -16'sd1);
      queue_word(KIND_PUSH, 32'sh0005_0000, 16'sd5);
      queue_word(KIND_PUSH, 32'shFFFB_0000, -16'sd5);
      for (int i = 1; i <= 10; i++) queue_word(KIND_PUSH, i * 32'sh0001_1111, 16'sd1);
      queue_word(KIND_PUSH, 32'sh1234_5678, 16'sh7FFF);
      queue_word(KIND_QUERY, 32'sh0, 16'sh8000);
      queue_word(KIND_POP, 32'sh0, 16'sh0);
      queue_word(KIND_POP, 32'sh0, 16'sh0);
      queue_word(KIND_CLEAR, 32'sh0, 16'sd3);
      queue_word(KIND_QUERY, 32'sh0, -16'sd3);
      queue_word(KIND_PUSH, 32'shFFFF_8000, 16'sd0);
      queue_word(KIND_POP, 32'sh0, 16'sd0);

      // The sender holds back here until every result of the opening words is in.
      wait_drained();
      random_started = 1'b1;
      push_bias = 50;
      for (int n = 0; n < 1500; n++) begin
         if (n % 40 == 0) push_bias = $urandom_range(15, 85);
         roll = $urandom_range(0, 99);
         if (roll < 2) kind = KIND_CLEAR;
         else if (roll < 10) kind = KIND_QUERY;
         else if ($urandom_range(0, 99) < push_bias) kind = KIND_PUSH;
         else kind = KIND_POP;
         case ($urandom_range(0, 3))
            0: smp = $urandom;
            1: smp = (int'($urandom_range(0, 6)) - 3) * 65536;
            2: begin
               case ($urandom_range(0, 3))
                  0: smp = 32'sh7FFF_FFFF;
                  1: smp = 32'sh8000_0000;
                  2: smp = 32'shFFFF_FFFF;
                  default: smp = 32'sh0;
               endcase
            end
            default: smp = int'($urandom_range(0, 524287)) - 262144;
         endcase
         if ($urandom_range(0, 9) < 7) filt = 16'(int'($urandom_range(0, 6)) - 3);
         else filt = 16'($urandom);
         queue_word(kind, smp, filt);
      end

      wait_drained();
      repeat (80) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
